// ===== design/tcw_pkg.sv =====
package tcw_pkg;

  localparam logic [1:0] ACT_WRITE = 2'd0;
  localparam logic [1:0] ACT_PUT   = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;
  localparam logic [1:0] ACT_CLEAR = 2'd3;

  localparam logic [7:0] NEWLINE_CODE = 8'd10;
  localparam logic [7:0] TEXT_COLOR_RESET = 8'd7;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] char_code;
    logic [7:0] cell_color;
    logic [6:0] pos_x;
    logic [4:0] pos_y;
  } item_t;

  typedef struct packed {
    logic [15:0] read_cell;
    logic [4:0]  cursor_row;
    logic [6:0]  cursor_column;
    logic        scrolled;
  } result_t;

  typedef struct packed {
    logic capture;
    logic write_char;
    logic new_line;
    logic put_cell;
    logic read_cell;
    logic latch_read;
    logic home;
    logic clr_sweep;
    logic copy_step;
    logic fill_step;
    logic fill_color;
    logic set_scroll;
  } cmd_t;

  typedef struct packed {
    logic [1:0] action;
    logic       is_newline;
    logic       row_end;
    logic       bottom;
    logic       copy_last;
    logic       sweep_last;
  } status_t;

endpackage

// ===== design/text_console_writer_core.sv =====
// A request is taken when start is high and busy is low; its result shows for one cycle with done.
// Plain writes, newlines and puts pass through EXEC to DONE; reads through EXEC, RDWAIT and DONE.
// A scroll moves each row up through the one write port (SCROLL, DRAIN) and zeroes the last row
// (ZERO); a clear blanks every cell in the text color (CLEAR). A new request is taken in the cycle
// after done, never while busy. After reset the cell store is swept to zero with busy high; the cursor
// homes and the text color returns to 7. The receiver cannot stall results; cfg_ready is always high.
module text_console_writer_core #(
  parameter int COLUMNS = 80,
  parameter int ROWS = 25
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  tcw_pkg::item_t   item,
  output logic             done,
  output tcw_pkg::result_t result,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [7:0]       cfg_data
);
  import tcw_pkg::*;

  cmd_t    cmd;
  status_t status;

  assign cfg_ready = 1'b1;

  tcw_ctrl u_ctrl (
    .clk(clk),
    .rst(rst),
    .start(start),
    .status(status),
    .cmd(cmd),
    .busy(busy),
    .done(done)
  );

  tcw_datapath #(
    .COLUMNS(COLUMNS),
    .ROWS(ROWS)
  ) u_datapath (
    .clk(clk),
    .rst(rst),
    .cmd(cmd),
    .status(status),
    .item(item),
    .cfg_valid(cfg_valid),
    .cfg_data(cfg_data),
    .result(result)
  );

endmodule

// ===== design/tcw_ram.sv =====
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== design/tcw_datapath.sv =====
module tcw_datapath #(
  parameter int COLUMNS = 80,
  parameter int ROWS = 25
) (
  input  logic             clk,
  input  logic             rst,
  input  tcw_pkg::cmd_t    cmd,
  output tcw_pkg::status_t status,
  input  tcw_pkg::item_t   item,
  input  logic             cfg_valid,
  input  logic [7:0]       cfg_data,
  output tcw_pkg::result_t result
);
  import tcw_pkg::*;

  localparam int CELLS = ROWS * COLUMNS;
  localparam int AW = $clog2(CELLS);
  localparam int RW = $clog2(ROWS);
  localparam int CW = $clog2(COLUMNS);
  localparam logic [AW-1:0] LAST = AW'(CELLS - 1);
  localparam logic [AW-1:0] COPY_LAST = AW'(CELLS - COLUMNS - 1);
  localparam logic [AW-1:0] COLS_A = AW'(COLUMNS);
  localparam logic [RW-1:0] ROW_LAST = RW'(ROWS - 1);
  localparam logic [CW-1:0] COL_LAST = CW'(COLUMNS - 1);

  item_t         req;
  logic [7:0]    text_color;
  logic [RW-1:0] row;
  logic [CW-1:0] col;
  logic [AW-1:0] cnt;
  logic          pend;
  logic [AW-1:0] pend_addr;
  logic [15:0]   cell_word;
  logic          scrolled;

  logic          in_range;
  logic          bottom;
  logic          row_end;
  logic [AW-1:0] pos_addr;
  logic [AW-1:0] cur_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [15:0]   wr_data;
  logic [AW-1:0] rd_addr;
  logic [15:0]   rd_data;

  assign in_range = ({25'd0, req.pos_x} < 32'(COLUMNS)) && ({27'd0, req.pos_y} < 32'(ROWS));
  assign bottom = (row == ROW_LAST);
  assign row_end = (col == COL_LAST);
  assign pos_addr = AW'(req.pos_y) * COLS_A + AW'(req.pos_x);
  assign cur_addr = AW'(row) * COLS_A + AW'(col);

  assign status.action = req.action;
  assign status.is_newline = (req.char_code == NEWLINE_CODE);
  assign status.row_end = row_end;
  assign status.bottom = bottom;
  assign status.copy_last = (cnt == COPY_LAST);
  assign status.sweep_last = (cnt == LAST);

  always_comb begin
    wr_en = 1'b0;
    wr_addr = cnt;
    wr_data = 16'd0;
    if (pend) begin
      wr_en = 1'b1;
      wr_addr = pend_addr;
      wr_data = rd_data;
    end else if (cmd.fill_step) begin
      wr_en = 1'b1;
      wr_addr = cnt;
      wr_data = cmd.fill_color ? {text_color, 8'd0} : 16'd0;
    end else if (cmd.write_char) begin
      wr_en = 1'b1;
      wr_addr = cur_addr;
      wr_data = {text_color, req.char_code};
    end else if (cmd.put_cell && in_range) begin
      wr_en = 1'b1;
      wr_addr = pos_addr;
      wr_data = {req.cell_color, req.char_code};
    end
  end

  assign rd_addr = cmd.copy_step ? (cnt + COLS_A) : pos_addr;

  tcw_ram #(
    .WIDTH(16),
    .DEPTH(CELLS)
  ) u_ram (
    .clk(clk),
    .wr_en(wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      text_color <= TEXT_COLOR_RESET;
      row <= '0;
      col <= '0;
      cnt <= '0;
      pend <= 1'b0;
    end else begin
      if (cfg_valid) begin
        text_color <= cfg_data;
      end
      pend <= cmd.copy_step;
      if (cmd.clr_sweep) begin
        cnt <= '0;
      end else if (cmd.copy_step || cmd.fill_step) begin
        cnt <= cnt + AW'(1);
      end
      if (cmd.home) begin
        row <= '0;
        col <= '0;
      end else if (cmd.new_line || (cmd.write_char && row_end)) begin
        col <= '0;
        if (!bottom) begin
          row <= row + RW'(1);
        end
      end else if (cmd.write_char) begin
        col <= col + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    pend_addr <= cnt;
    if (cmd.capture) begin
      req <= item;
      cell_word <= 16'd0;
      scrolled <= 1'b0;
    end else begin
      if (cmd.latch_read) begin
        cell_word <= in_range ? rd_data : 16'd0;
      end
      if (cmd.set_scroll) begin
        scrolled <= 1'b1;
      end
    end
  end

  assign result.read_cell = cell_word;
  assign result.cursor_row = 5'(row);
  assign result.cursor_column = 7'(col);
  assign result.scrolled = scrolled;

endmodule

// ===== design/tcw_ctrl.sv =====
module tcw_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  tcw_pkg::status_t status,
  output tcw_pkg::cmd_t    cmd,
  output logic             busy,
  output logic             done
);
  import tcw_pkg::*;

  localparam logic [3:0] S_INIT   = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_EXEC   = 4'd2;
  localparam logic [3:0] S_RDWAIT = 4'd3;
  localparam logic [3:0] S_SCROLL = 4'd4;
  localparam logic [3:0] S_DRAIN  = 4'd5;
  localparam logic [3:0] S_ZERO   = 4'd6;
  localparam logic [3:0] S_CLEAR  = 4'd7;
  localparam logic [3:0] S_DONE   = 4'd8;

  logic [3:0] state;
  logic [3:0] state_next;

  always_comb begin
    cmd = '0;
    state_next = state;
    unique case (state)
      S_INIT: begin
        cmd.fill_step = 1'b1;
        if (status.sweep_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (status.action)
          ACT_WRITE: begin
            if (status.is_newline) begin
              cmd.new_line = 1'b1;
            end else begin
              cmd.write_char = 1'b1;
            end
            if (status.bottom && (status.is_newline || status.row_end)) begin
              cmd.clr_sweep = 1'b1;
              cmd.set_scroll = 1'b1;
              state_next = S_SCROLL;
            end else begin
              state_next = S_DONE;
            end
          end
          ACT_PUT: begin
            cmd.put_cell = 1'b1;
            state_next = S_DONE;
          end
          ACT_READ: begin
            cmd.read_cell = 1'b1;
            state_next = S_RDWAIT;
          end
          ACT_CLEAR: begin
            cmd.home = 1'b1;
            cmd.clr_sweep = 1'b1;
            state_next = S_CLEAR;
          end
          default: state_next = S_DONE;
        endcase
      end
      S_RDWAIT: begin
        cmd.latch_read = 1'b1;
        state_next = S_DONE;
      end
      S_SCROLL: begin
        cmd.copy_step = 1'b1;
        if (status.copy_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_next = S_ZERO;
      end
      S_ZERO: begin
        cmd.fill_step = 1'b1;
        if (status.sweep_last) begin
          state_next = S_DONE;
        end
      end
      S_CLEAR: begin
        cmd.fill_step = 1'b1;
        cmd.fill_color = 1'b1;
        if (status.sweep_last) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_DONE);

endmodule

// ===== tb/sv/text_console_writer_core_test.sv =====
`timescale 1ns / 1ps

module text_console_writer_core_test;
  import tcw_pkg::*;

  localparam int COLUMNS = 80;
  localparam int ROWS = 25;
  localparam int CELLS = COLUMNS * ROWS;
  localparam int MAX_REPORTS = 10;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  item_t item = '0;
  logic done;
  result_t result;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [7:0] cfg_data = '0;

  logic [15:0] shadow_cells [CELLS];
  int unsigned shadow_row;
  int unsigned shadow_col;
  logic [7:0] shadow_color;
  result_t pending_results [$];
  result_t oldest_result;
  int unsigned failures = 0;
  int line_left = 0;
  int burst_left = 0;

  text_console_writer_core #(
    .COLUMNS(COLUMNS),
    .ROWS(ROWS)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .item(item),
    .done(done),
    .result(result),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic bit shadow_new_line();
    shadow_col = 0;
    if (shadow_row + 1 < ROWS) begin
      shadow_row++;
      return 1'b0;
    end
    for (int i = 0; i < CELLS; i++) begin
      shadow_cells[i] = (i + COLUMNS < CELLS) ? shadow_cells[i + COLUMNS] : 16'h0000;
    end
    return 1'b1;
  endfunction

  function automatic result_t predict_console_result(item_t req);
    result_t res;
    bit in_range;
    res = '0;
    in_range = (req.pos_x < COLUMNS) && (req.pos_y < ROWS);
    case (req.action)
      ACT_WRITE: begin
        if (req.char_code == NEWLINE_CODE) begin
          res.scrolled = shadow_new_line();
        end else begin
          shadow_cells[shadow_row * COLUMNS + shadow_col] = {shadow_color, req.char_code};
          shadow_col++;
          if (shadow_col >= COLUMNS) begin
            res.scrolled = shadow_new_line();
          end
        end
      end
      ACT_PUT: begin
        if (in_range) begin
          shadow_cells[req.pos_y * COLUMNS + req.pos_x] = {req.cell_color, req.char_code};
        end
      end
      ACT_READ: begin
        if (in_range) begin
          res.read_cell = shadow_cells[req.pos_y * COLUMNS + req.pos_x];
        end
      end
      default: begin
        for (int i = 0; i < CELLS; i++) begin
          shadow_cells[i] = {shadow_color, 8'h00};
        end
        shadow_row = 0;
        shadow_col = 0;
      end
    endcase
    res.cursor_row = shadow_row[4:0];
    res.cursor_column = shadow_col[6:0];
    return res;
  endfunction

  function automatic item_t make_item(logic [1:0] act, logic [7:0] ch, logic [7:0] color,
                                      logic [6:0] x, logic [4:0] y);
    item_t req;
    req.action = act;
    req.char_code = ch;
    req.cell_color = color;
    req.pos_x = x;
    req.pos_y = y;
    return req;
  endfunction

  function automatic item_t text_item();
    item_t req;
    logic [7:0] ch;
    req = item_t'($urandom);
    req.action = ACT_WRITE;
    if (line_left > 0) begin
      do ch = 8'($urandom_range(0, 255)); while (ch == NEWLINE_CODE);
      req.char_code = ch;
      line_left--;
    end else begin
      req.char_code = NEWLINE_CODE;
      line_left = ($urandom_range(0, 4) == 0) ? $urandom_range(70, 85) : $urandom_range(0, 12);
    end
    return req;
  endfunction

  function automatic item_t mixed_item();
    item_t req;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 50) begin
      return text_item();
    end
    req = item_t'($urandom);
    if ($urandom_range(0, 4) != 0) begin
      req.pos_x = 7'($urandom_range(0, COLUMNS - 1));
      req.pos_y = 5'($urandom_range(0, ROWS - 1));
    end
    if (pick < 66) begin
      req.action = ACT_PUT;
    end else if (pick < 98) begin
      req.action = ACT_READ;
    end else begin
      req.action = ACT_CLEAR;
    end
    return req;
  endfunction

  task automatic send_item(item_t req);
    start <= 1'b1;
    item <= req;
    do @(posedge clk); while (busy);
    pending_results.push_back(predict_console_result(req));
  endtask

  task automatic drain_results();
    start <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // Requests go out in bursts; between bursts the sender idles, and now and then
  // it holds off until the block has answered everything.
  task automatic send_paced(item_t req);
    send_item(req);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      if ($urandom_range(0, 24) == 0) begin
        drain_results();
      end else begin
        start <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 7);
    end
  endtask

  task automatic write_text_color(logic [7:0] color);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data <= color;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    shadow_color = color;
  endtask

  task automatic run_mixed(int count);
    repeat (count) send_paced(mixed_item());
  endtask

  task automatic test_blank_screen();
    send_paced(make_item(ACT_READ, 8'h00, 8'h00, 7'd0, 5'd0));
    send_paced(make_item(ACT_READ, 8'hFF, 8'hFF, 7'd79, 5'd24));
    send_paced(make_item(ACT_READ, 8'h00, 8'h00, 7'd127, 5'd31));
  endtask

  task automatic test_put_and_read();
    send_paced(make_item(ACT_PUT, 8'hFF, 8'h00, 7'd0, 5'd0));
    send_paced(make_item(ACT_PUT, 8'h00, 8'hFF, 7'd79, 5'd24));
    send_paced(make_item(ACT_PUT, 8'hAA, 8'h55, 7'd80, 5'd3));
    send_paced(make_item(ACT_PUT, 8'h55, 8'hAA, 7'd5, 5'd25));
    send_paced(make_item(ACT_READ, 8'h00, 8'h00, 7'd0, 5'd0));
    send_paced(make_item(ACT_READ, 8'h00, 8'h00, 7'd79, 5'd24));
    send_paced(make_item(ACT_READ, 8'h00, 8'h00, 7'd80, 5'd3));
    send_paced(make_item(ACT_READ, 8'h00, 8'h00, 7'd5, 5'd24));
  endtask

  task automatic test_write_and_newline();
    send_paced(make_item(ACT_WRITE, 8'h41, 8'hFF, 7'd127, 5'd31));
    send_paced(make_item(ACT_WRITE, 8'hFF, 8'h00, 7'd0, 5'd0));
    send_paced(make_item(ACT_WRITE, 8'h00, 8'h12, 7'd3, 5'd4));
    send_paced(make_item(ACT_WRITE, NEWLINE_CODE, 8'h00, 7'd0, 5'd0));
    send_paced(make_item(ACT_WRITE, 8'h7E, 8'h00, 7'd0, 5'd0));
    send_paced(make_item(ACT_READ, 8'h00, 8'h00, 7'd2, 5'd0));
    send_paced(make_item(ACT_READ, 8'h00, 8'h00, 7'd0, 5'd1));
  endtask

  task automatic test_clear();
    send_paced(make_item(ACT_CLEAR, 8'hFF, 8'hFF, 7'd127, 5'd31));
    send_paced(make_item(ACT_READ, 8'h00, 8'h00, 7'd0, 5'd0));
    send_paced(make_item(ACT_READ, 8'h00, 8'h00, 7'd79, 5'd24));
  endtask

  // Short lines walk the cursor to the bottom row, where every newline and every
  // wrap at the row end scrolls the screen.
  task automatic test_scroll_lines();
    send_paced(make_item(ACT_CLEAR, 8'h00, 8'h00, 7'd0, 5'd0));
    line_left = 0;
    repeat (30) begin
      line_left = $urandom_range(0, 3);
      repeat (line_left + 1) send_paced(text_item());
    end
    repeat (3) begin
      line_left = $urandom_range(78, 82);
      repeat (line_left) send_paced(text_item());
      send_paced(make_item(ACT_READ, 8'h00, 8'h00, 7'($urandom_range(0, COLUMNS - 1)),
                           5'($urandom_range(ROWS - 3, ROWS - 1))));
    end
    line_left = 0;
    repeat (40) send_paced(text_item());
  endtask

  task automatic test_color_extremes();
    write_text_color(8'h00);
    send_paced(make_item(ACT_CLEAR, 8'h00, 8'h00, 7'd0, 5'd0));
    run_mixed(100);
    write_text_color(8'hFF);
    send_paced(make_item(ACT_CLEAR, 8'h00, 8'h00, 7'd0, 5'd0));
    run_mixed(100);
  endtask

  task automatic test_random_traffic();
    repeat (3) begin
      write_text_color(8'($urandom_range(0, 255)));
      run_mixed(60);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        failures++;
        if (failures <= MAX_REPORTS) begin
          $display("Unexpected result: cell %h row %0d col %0d scrolled %0b",
                   result.read_cell, result.cursor_row, result.cursor_column, result.scrolled);
        end
      end else begin
        oldest_result = pending_results.pop_front();
        if (result.read_cell !== oldest_result.read_cell ||
            result.cursor_row !== oldest_result.cursor_row ||
            result.cursor_column !== oldest_result.cursor_column ||
            result.scrolled !== oldest_result.scrolled) begin
          failures++;
          if (failures <= MAX_REPORTS) begin
            $display("Mismatch: expected cell %h row %0d col %0d scrolled %0b",
                     oldest_result.read_cell, oldest_result.cursor_row,
                     oldest_result.cursor_column, oldest_result.scrolled);
            $display("          actual   cell %h row %0d col %0d scrolled %0b",
                     result.read_cell, result.cursor_row, result.cursor_column,
                     result.scrolled);
          end
        end
      end
    end
  end

  initial begin
    foreach (shadow_cells[i]) begin
      shadow_cells[i] = 16'h0000;
    end
    shadow_row = 0;
    shadow_col = 0;
    shadow_color = TEXT_COLOR_RESET;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_blank_screen();
    test_put_and_read();
    test_write_and_newline();
    test_clear();
    test_scroll_lines();
    test_color_extremes();
    test_random_traffic();
    drain_results();
    repeat (10) @(posedge clk);
    if (failures == 0 && pending_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
